FILE: rtl/core/array_bst_insert_and_dump_assert.svh
// assertion macros for the array bst insert and dump block
// used by the port checker; no other dependencies
`ifndef ARRAY_BST_INSERT_AND_DUMP_ASSERT_SVH
`define ARRAY_BST_INSERT_AND_DUMP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ABST_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("abst check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define ABST_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("abst check failed: next-cycle rule");

`endif

FILE: rtl/core/abst_pkg.sv
// shared types and constants for the array bst insert and dump block
// no dependencies
package abst_pkg;

    localparam int MAX_SLOTS_DEF = 63;
    localparam int KEY_W         = 32;
    localparam int CFG_W         = 6;
    localparam int STATUS_W      = 3;
    localparam int SLOT_OUT_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd63;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED      = 3'd0,
        ST_DUPLICATE     = 3'd1,
        ST_OUT_OF_BOUNDS = 3'd2,
        ST_DUMPED        = 3'd3,
        ST_EMPTY         = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DUMP,
        S_DRAIN,
        S_FINISH
    } t_state;

    // one slot of the tree memory
    typedef struct packed {
        logic                    used;
        logic signed [KEY_W-1:0] key;
    } t_slot_entry;

endpackage

FILE: rtl/core/abst_store.sv
// slot memory of the array bst: one write port, one registered read port
// depends on abst_pkg for the entry type
module abst_store #(
    parameter int DEPTH = abst_pkg::MAX_SLOTS_DEF + 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  abst_pkg::t_slot_entry       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    output abst_pkg::t_slot_entry       o_rd_data
);
    import abst_pkg::*;

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/array_bst_insert_and_dump.sv
// top level of the array bst insert and dump block
// depends on abst_pkg and abst_store
//
// Binary search tree of signed 32-bit keys held implicitly in one slot memory:
// root at slot 1, smaller keys go to slot 2i, larger or different to 2i+1.
// An item is taken on a clock edge with start high and busy low. op 0 inserts
// key and gives exactly one result (inserted, duplicate or out of bounds, with
// the slot where the walk stopped). op 1 dumps all stored keys in ascending
// order, one result per key, the final one with o_last set; an empty tree gives
// a single tree-empty result. Results appear on o_valid for one cycle each and
// cannot be held off by the receiver; at most one result per cycle.
// Timing: the memory has one registered read port, and the walk reads one
// tree level per cycle. An insert keeps busy high until its walk stops, and
// a new item is taken only once busy is low again. A dump scans every slot
// position in in-order sequence, one per cycle, and keeps busy high until its
// final result is registered. After reset a clearing pass marks every slot
// free while busy is high; configuration writes are taken at any time.
// slots_in_use above MAX_SLOTS acts as MAX_SLOTS; keys stored before the
// bound was lowered are still found and dumped.
module array_bst_insert_and_dump #(
    parameter int MAX_SLOTS = abst_pkg::MAX_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic signed [abst_pkg::KEY_W-1:0]   i_key,
    // configuration: slots_in_use
    input  logic                                i_cfg_we,
    input  logic [abst_pkg::CFG_W-1:0]          i_cfg_wdata,
    // result strobe and payload
    output logic                                o_valid,
    output logic [abst_pkg::STATUS_W-1:0]       o_status,
    output logic signed [abst_pkg::KEY_W-1:0]   o_key_out,
    output logic [abst_pkg::SLOT_OUT_W-1:0]     o_slot,
    output logic                                o_last
);
    import abst_pkg::*;

    // slot address width, and walk index width (one more bit for the
    // children of the deepest stored level)
    localparam int AW    = $clog2(MAX_SLOTS + 1);
    localparam int SW    = AW + 1;
    localparam int CW    = (SW > CFG_W) ? SW : CFG_W;
    localparam int DEPTH = MAX_SLOTS + 1;

    localparam logic [AW-1:0] MAX_A   = AW'(MAX_SLOTS);
    localparam logic [SW-1:0] MAX_S   = SW'(MAX_SLOTS);
    localparam logic [AW-1:0] CNT_END = {AW{1'b1}};
    localparam logic [AW-1:0] ROOT_A  = AW'(1);
    localparam logic [SW-1:0] ROOT_S  = SW'(1);

    // node visited at in-order position c of the perfect tree of 2^AW-1 nodes:
    // drop the trailing zeros of c and the bit above them
    function automatic logic [AW-1:0] f_inorder_node(input logic [AW-1:0] c);
        logic [AW:0] v;
        int unsigned tz;
        tz = 0;
        for (int i = AW - 1; i >= 0; i--) begin
            if (c[i]) begin
                tz = i;
            end
        end
        v = {1'b1, c} >> (tz + 1);
        return v[AW-1:0];
    endfunction

    // state and control registers
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_rd_pend, n_rd_pend;
    logic               r_hold_valid, n_hold_valid;
    logic               r_valid, n_valid;

    // payload registers
    logic [SW-1:0]              r_idx, n_idx;
    logic signed [KEY_W-1:0]    r_key, n_key;
    logic [AW-1:0]              r_cnt, n_cnt;
    logic [AW-1:0]              r_rd_node, n_rd_node;
    logic signed [KEY_W-1:0]    r_hold_key, n_hold_key;
    logic [AW-1:0]              r_hold_slot, n_hold_slot;
    t_status                    r_status, n_status;
    logic signed [KEY_W-1:0]    r_key_out, n_key_out;
    logic [SLOT_OUT_W-1:0]      r_slot, n_slot;
    logic                       r_last, n_last;

    // memory port
    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    t_slot_entry    mem_wr_data;
    logic           mem_rd_en;
    logic [AW-1:0]  mem_rd_addr;
    t_slot_entry    mem_rd_data;

    // walk decision, valid in S_WALK where mem_rd_data belongs to r_idx
    logic           idx_over_max;
    logic           past_bound;
    logic           key_hit;
    logic           key_less;
    logic           descend;
    logic           do_insert;
    logic [SW-1:0]  child;
    logic [CW-1:0]  idx_c;
    logic [CW-1:0]  cfg_c;

    // dump scan
    logic           take_node;
    logic [AW-1:0]  scan_node;

    // slot numbers masked to the output width
    logic [SW+SLOT_OUT_W-1:0] idx_wide;
    logic [AW+SLOT_OUT_W-1:0] hold_wide;

    abst_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign idx_c = CW'(r_idx);
    assign cfg_c = CW'(r_cfg);

    // slots past MAX_SLOTS are never stored, so no read is needed there;
    // past the configured bound a used slot is still followed
    assign idx_over_max = (r_idx > MAX_S);
    assign past_bound   = idx_over_max || (idx_c > cfg_c);
    assign key_hit      = !idx_over_max && mem_rd_data.used && (mem_rd_data.key == r_key);
    assign key_less     = (r_key < mem_rd_data.key);
    assign descend      = !idx_over_max && mem_rd_data.used && !key_hit;
    assign do_insert    = !idx_over_max && !mem_rd_data.used && !past_bound;
    assign child        = {r_idx[AW-1:0], !key_less};

    assign scan_node = f_inorder_node(r_cnt);
    // a read issued last cycle by the scan found a stored key
    assign take_node = r_rd_pend && mem_rd_data.used;

    assign idx_wide  = {{SLOT_OUT_W{1'b0}}, r_idx};
    assign hold_wide = {{SLOT_OUT_W{1'b0}}, r_hold_slot};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == MAX_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = i_op ? S_DUMP : S_WALK;
                end
            end
            S_WALK: begin
                if (!descend) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (r_cnt == CNT_END) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath, memory accesses and results
    always_comb begin
        mem_wr_en        = 1'b0;
        mem_wr_addr      = r_idx[AW-1:0];
        mem_wr_data.used = 1'b1;
        mem_wr_data.key  = r_key;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = r_idx[AW-1:0];

        n_idx        = r_idx;
        n_key        = r_key;
        n_clr_addr   = r_clr_addr;
        n_cnt        = r_cnt;
        n_rd_pend    = 1'b0;
        n_rd_node    = r_rd_node;
        n_hold_valid = r_hold_valid;
        n_hold_key   = r_hold_key;
        n_hold_slot  = r_hold_slot;

        n_valid   = 1'b0;
        n_status  = r_status;
        n_key_out = r_key_out;
        n_slot    = r_slot;
        n_last    = r_last;

        case (r_state)
            S_CLEAR: begin
                // mark one slot free per cycle
                mem_wr_en        = 1'b1;
                mem_wr_addr      = r_clr_addr;
                mem_wr_data.used = 1'b0;
                mem_wr_data.key  = '0;
                n_clr_addr       = r_clr_addr + ROOT_A;
            end
            S_IDLE: begin
                if (start) begin
                    // root read goes out with the transfer
                    n_key        = i_key;
                    n_idx        = ROOT_S;
                    n_cnt        = ROOT_A;
                    n_hold_valid = 1'b0;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = ROOT_A;
                end
            end
            S_WALK: begin
                if (descend) begin
                    // the write only comes at the end of a walk, so a read
                    // never meets a pending write to the same slot
                    n_idx       = child;
                    mem_rd_en   = (child <= MAX_S);
                    mem_rd_addr = child[AW-1:0];
                end else begin
                    mem_wr_en = do_insert;
                    n_valid   = 1'b1;
                    n_key_out = r_key;
                    n_slot    = idx_wide[SLOT_OUT_W-1:0];
                    n_last    = 1'b1;
                    if (key_hit) begin
                        n_status = ST_DUPLICATE;
                    end else if (do_insert) begin
                        n_status = ST_INSERTED;
                    end else begin
                        n_status = ST_OUT_OF_BOUNDS;
                    end
                end
            end
            S_DUMP: begin
                // stored slots are ancestor-closed, so an in-order scan of all
                // positions that skips free slots gives the tree's in-order walk
                mem_rd_en   = (scan_node <= MAX_A);
                mem_rd_addr = scan_node;
                n_rd_pend   = mem_rd_en;
                n_rd_node   = scan_node;
                n_cnt       = r_cnt + ROOT_A;
            end
            S_DRAIN: begin
            end
            S_FINISH: begin
                n_valid      = 1'b1;
                n_last       = 1'b1;
                n_hold_valid = 1'b0;
                if (r_hold_valid) begin
                    n_status  = ST_DUMPED;
                    n_key_out = r_hold_key;
                    n_slot    = hold_wide[SLOT_OUT_W-1:0];
                end else begin
                    n_status  = ST_EMPTY;
                    n_key_out = '0;
                    n_slot    = '0;
                end
            end
            default: begin
            end
        endcase

        // one key held back so the final one can carry o_last
        if (take_node) begin
            if (r_hold_valid) begin
                n_valid   = 1'b1;
                n_status  = ST_DUMPED;
                n_key_out = r_hold_key;
                n_slot    = hold_wide[SLOT_OUT_W-1:0];
                n_last    = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold_key   = mem_rd_data.key;
            n_hold_slot  = r_rd_node;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cfg        <= CFG_RESET;
            r_clr_addr   <= '0;
            r_rd_pend    <= 1'b0;
            r_hold_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_rd_pend    <= n_rd_pend;
            r_hold_valid <= n_hold_valid;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_key       <= n_key;
        r_cnt       <= n_cnt;
        r_rd_node   <= n_rd_node;
        r_hold_key  <= n_hold_key;
        r_hold_slot <= n_hold_slot;
        r_status    <= n_status;
        r_key_out   <= n_key_out;
        r_slot      <= n_slot;
        r_last      <= n_last;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_key_out = r_key_out;
    assign o_slot    = r_slot;
    assign o_last    = r_last;

endmodule

FILE: rtl/core/abst_checker.sv
// port-level checker for array_bst_insert_and_dump, bound to the top level
// depends on abst_pkg and array_bst_insert_and_dump_assert.svh
`include "array_bst_insert_and_dump_assert.svh"

module abst_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_valid,
    input logic [abst_pkg::STATUS_W-1:0]        o_status,
    input logic signed [abst_pkg::KEY_W-1:0]    o_key_out,
    input logic [abst_pkg::SLOT_OUT_W-1:0]      o_slot,
    input logic                                 o_last
);
    import abst_pkg::*;

    // a transfer always starts work
    `ABST_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // insert outcomes are single results
    `ABST_ASSERT_NOW(a_insert_last, i_clk, i_rst_n, o_valid && (o_status == ST_INSERTED || o_status == ST_DUPLICATE || o_status == ST_OUT_OF_BOUNDS), o_last)

    // empty tree result is fixed
    `ABST_ASSERT_NOW(a_empty_form, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY), o_last && (o_key_out == '0) && (o_slot == '0))

    // nothing follows the final result of an item
    `ABST_ASSERT_NEXT(a_quiet_after_last, i_clk, i_rst_n, o_valid && o_last, !o_valid)

endmodule

bind array_bst_insert_and_dump abst_checker u_abst_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_status  (o_status),
    .o_key_out (o_key_out),
    .o_slot    (o_slot),
    .o_last    (o_last)
);

FILE: sim/tb.sv
// self-checking testbench for array_bst_insert_and_dump: directed table, then random phases
// depends on abst_pkg and the rtl top level; predicts every result with its own tree model
`timescale 1ns / 100ps

module tb;
    import abst_pkg::*;

    localparam int TREE_SLOTS  = MAX_SLOTS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int END_CYCLES  = 70;
    localparam int DIR_ROWS    = 23;
    localparam int PHASES      = 9;
    localparam int MAX_PRINTS  = 40;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_e;

    // one result as the block presents it
    typedef struct packed {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [SLOT_OUT_W-1:0]   slot;
        logic                    last;
    } result_t;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        row_kind_e               kind;
        logic                    op;
        logic [KEY_W-1:0]        value;
        logic                    typed;
        t_status                 exp_status;
        logic [KEY_W-1:0]        exp_key;
        logic [SLOT_OUT_W-1:0]   exp_slot;
    } dir_row_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_op;
    logic signed [KEY_W-1:0]   i_key;
    logic                      i_cfg_we;
    logic [CFG_W-1:0]          i_cfg_wdata;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic signed [KEY_W-1:0]   o_key_out;
    logic [SLOT_OUT_W-1:0]     o_slot;
    logic                      o_last;

    // tree model: keys per slot, occupancy and the usable bound
    logic signed [KEY_W-1:0]   tree_key  [0:TREE_SLOTS];
    bit                        tree_used [0:TREE_SLOTS];
    int                        slot_bound;

    result_t                   step_results[$];   // results of the item just transferred
    result_t                   pending_results[$]; // results still to come from the block
    int                        mismatch_count;

    dir_row_t                  dir_table [DIR_ROWS];
    int                        phase_bounds [PHASES];

    array_bst_insert_and_dump i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_key_out   (o_key_out),
        .o_slot      (o_slot),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // tree predictor
    // ------------------------------------------------------------------

    // insert walk: a free slot within the bound takes the key, a used slot is
    // followed even past a lowered bound, a free slot past the bound stops it
    function automatic result_t predict_insert(logic signed [KEY_W-1:0] key);
        int      idx;
        int      lim;
        result_t r;
        lim = (slot_bound > TREE_SLOTS) ? TREE_SLOTS : slot_bound;
        idx = 1;
        r.key  = key;
        r.last = 1'b1;
        while (1) begin
            if (idx > lim && !(idx <= TREE_SLOTS && tree_used[idx])) begin
                r.status = ST_OUT_OF_BOUNDS;
                r.slot   = SLOT_OUT_W'(idx);
                return r;
            end
            if (!tree_used[idx]) begin
                tree_used[idx] = 1'b1;
                tree_key[idx]  = key;
                r.status = ST_INSERTED;
                r.slot   = SLOT_OUT_W'(idx);
                return r;
            end
            if (tree_key[idx] == key) begin
                r.status = ST_DUPLICATE;
                r.slot   = SLOT_OUT_W'(idx);
                return r;
            end
            idx = (key < tree_key[idx]) ? 2 * idx : 2 * idx + 1;
        end
    endfunction

    // in-order walk of the subtree under idx, ascending keys
    function automatic void dump_subtree(int idx);
        result_t r;
        if (idx < 1 || idx > TREE_SLOTS || !tree_used[idx])
            return;
        dump_subtree(2 * idx);
        r.status = ST_DUMPED;
        r.key    = tree_key[idx];
        r.slot   = SLOT_OUT_W'(idx);
        r.last   = 1'b0;
        step_results.push_back(r);
        dump_subtree(2 * idx + 1);
    endfunction

    function automatic void predict_item(logic op, logic signed [KEY_W-1:0] key);
        result_t r;
        step_results.delete();
        if (op == OP_DUMP) begin
            dump_subtree(1);
            if (step_results.size() == 0) begin
                r.status = ST_EMPTY;
                r.key    = '0;
                r.slot   = '0;
                r.last   = 1'b1;
                step_results.push_back(r);
            end else begin
                // mark the final key of the dump
                r = step_results.pop_back();
                r.last = 1'b1;
                step_results.push_back(r);
            end
        end else begin
            step_results.push_back(predict_insert(key));
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic dir_row_t cfg_row(logic [KEY_W-1:0] v);
        dir_row_t row;
        row = '0;
        row.kind  = ROW_CFG;
        row.value = v;
        return row;
    endfunction

    function automatic dir_row_t item_row(logic op, logic [KEY_W-1:0] key);
        dir_row_t row;
        row = '0;
        row.kind  = ROW_ITEM;
        row.op    = op;
        row.value = key;
        return row;
    endfunction

    // item whose single result is obvious and typed in directly
    function automatic dir_row_t checked_row(logic op, logic [KEY_W-1:0] key, t_status st,
                                             logic [KEY_W-1:0] ekey, int eslot);
        dir_row_t row;
        row = item_row(op, key);
        row.typed      = 1'b1;
        row.exp_status = st;
        row.exp_key    = ekey;
        row.exp_slot   = SLOT_OUT_W'(eslot);
        return row;
    endfunction

    // mostly back-to-back, sometimes a few cycles, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // keys: stored ones for duplicates and deep walks, extremes, near values, anything
    function automatic logic [KEY_W-1:0] pick_key();
        int stored[$];
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                for (int i = 1; i <= TREE_SLOTS; i++)
                    if (tree_used[i])
                        stored.push_back(i);
                if (stored.size() != 0)
                    return tree_key[stored[$urandom_range(0, stored.size() - 1)]];
                return $urandom;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return '0;
                    3: return '1;
                    default: return 32'd1;
                endcase
            end
            4, 5: return $urandom_range(0, 64) - 32;
            default: return $urandom;
        endcase
    endfunction

    // hold start low until every pending result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0 || busy);
    endtask

    task automatic write_slot_bound(int v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slot_bound = v & ((1 << CFG_W) - 1);
    endtask

    // one item transfer; start stays high afterwards so the next item can follow
    task automatic send_item(logic op, logic [KEY_W-1:0] key, logic typed, result_t typed_exp);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            drain();
        end else begin
            gap = pick_gap();
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        do
            @(posedge i_clk);
        while (busy);
        predict_item(op, key);
        if (typed)
            pending_results.push_back(typed_exp);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // result checker: every strobe is matched with the oldest pending result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        result_t want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_key_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", KEY_W'(o_status), KEY_W'(want.status));
                if (o_key_out !== want.key)
                    report_mismatch("key_out", o_key_out, want.key);
                if (o_slot !== want.slot)
                    report_mismatch("slot", KEY_W'(o_slot), KEY_W'(want.slot));
                if (o_last !== want.last)
                    report_mismatch("last", KEY_W'(o_last), KEY_W'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without an item transfer or a result ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (o_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int n_items;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_INSERT;
        i_key       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        mismatch_count = 0;
        slot_bound     = CFG_RESET;
        for (int i = 0; i <= TREE_SLOTS; i++) begin
            tree_used[i] = 1'b0;
            tree_key[i]  = '0;
        end

        // directed part: bound of zero on an empty tree, extremes, a chain that
        // runs off the bottom, then a shrunk bound that still finds deep keys
        dir_table = '{
            cfg_row(0),
            checked_row(OP_DUMP, 32'h5a5a_5a5a, ST_EMPTY, '0, 0),
            checked_row(OP_INSERT, KEY_MAX, ST_OUT_OF_BOUNDS, KEY_MAX, 1),
            cfg_row(63),
            checked_row(OP_INSERT, 32'd0, ST_INSERTED, 32'd0, 1),
            checked_row(OP_INSERT, 32'd0, ST_DUPLICATE, 32'd0, 1),
            checked_row(OP_INSERT, KEY_MIN, ST_INSERTED, KEY_MIN, 2),
            checked_row(OP_INSERT, KEY_MAX, ST_INSERTED, KEY_MAX, 3),
            item_row(OP_INSERT, -32'sd1),
            item_row(OP_INSERT, 32'd1),
            item_row(OP_DUMP, 32'hffff_ffff),
            checked_row(OP_INSERT, KEY_MIN, ST_DUPLICATE, KEY_MIN, 2),
            item_row(OP_INSERT, 32'd2),
            item_row(OP_INSERT, 32'd3),
            item_row(OP_INSERT, 32'd4),
            item_row(OP_INSERT, 32'd5),
            cfg_row(1),
            item_row(OP_INSERT, 32'd4),
            item_row(OP_INSERT, 32'd6),
            cfg_row(0),
            item_row(OP_INSERT, 32'd3),
            item_row(OP_DUMP, 32'd0),
            cfg_row(63)
        };

        // synchronous reset, then the block runs its clearing pass
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG)
                write_slot_bound(int'(dir_table[i].value));
            else
                send_item(dir_table[i].op, dir_table[i].value, dir_table[i].typed,
                          '{dir_table[i].exp_status, dir_table[i].exp_key,
                            dir_table[i].exp_slot, 1'b1});
        end

        // random phases, each under its own bound; the write between phases
        // also makes the sender wait until everything has come back
        phase_bounds = '{63, 31, 62, 15, 7, 1, 0, 47, 63};
        phase_bounds[7] = $urandom_range(0, 63);
        for (int phase = 0; phase < PHASES; phase++) begin
            write_slot_bound(phase_bounds[phase]);
            n_items = $urandom_range(20, 32);
            repeat (n_items) begin
                if ($urandom_range(0, 99) < 12)
                    send_item(OP_DUMP, $urandom, 1'b0, '0);
                else
                    send_item(OP_INSERT, pick_key(), 1'b0, '0);
            end
        end

        // wait for the last results, then let a full dump's worth of cycles pass
        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
